// File: design/mm_pkg.sv
package mm_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned IN_ELEM_W = 16;
  localparam int unsigned VALUE_W   = 35;
  localparam int unsigned DIM_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  // Request kinds carried in the input tuser.
  localparam logic [KIND_W-1:0] KIND_LOAD_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_COLS = 2'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_OUT,
    ST_ERR
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_first;
    logic wr_second;
    logic issue;
    logic first;
    logic last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
  } dp_sts_t;

endpackage

// File: design/mm_datapath.sv
module mm_datapath #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned ELEM_WIDTH = 16,
  parameter int unsigned DEPTH      = MAX_DIM * MAX_DIM,
  parameter int unsigned AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mm_pkg::dp_cmd_t                      cmd,
  input  logic [AW-1:0]                        wr_addr,
  input  logic signed [mm_pkg::IN_ELEM_W-1:0]  wr_data,
  input  logic [AW-1:0]                        rd_addr_first,
  input  logic [AW-1:0]                        rd_addr_second,
  output mm_pkg::dp_sts_t                      sts,
  output logic signed [mm_pkg::VALUE_W-1:0]    acc_value
);
  import mm_pkg::*;

  logic signed [ELEM_WIDTH-1:0] first_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] second_mem [DEPTH];

  logic signed [31:0]             wr_ext;
  logic signed [ELEM_WIDTH-1:0]   wr_elem;
  logic signed [ELEM_WIDTH-1:0]   a_r, b_r;
  logic signed [2*ELEM_WIDTH-1:0] prod_full;
  logic signed [VALUE_W-1:0]      prod_r;
  logic signed [VALUE_W-1:0]      acc_r, acc_nxt;
  logic v1_r, first1_r, last1_r;
  logic v2_r, first2_r, last2_r;
  logic done_r;

  // Loaded value is sign-extended, then kept at the element width.
  assign wr_ext  = 32'(wr_data);
  assign wr_elem = wr_ext[ELEM_WIDTH-1:0];

  // Element stores: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (cmd.wr_first) begin
      first_mem[wr_addr] <= wr_elem;
    end
    if (cmd.wr_second) begin
      second_mem[wr_addr] <= wr_elem;
    end
    a_r <= first_mem[rd_addr_first];
    b_r <= second_mem[rd_addr_second];
  end

  // Multiply stage, product resized to the result width.
  assign prod_full = a_r * b_r;

  always_ff @(posedge clk) begin
    prod_r <= VALUE_W'(prod_full);
    acc_r  <= acc_nxt;
  end

  // Accumulate: the first term of an element restarts the sum.
  always_comb begin
    acc_nxt = acc_r;
    if (v2_r) begin
      acc_nxt = first2_r ? prod_r : acc_r + prod_r;
    end
  end

  // Tags that follow each term through the read and multiply stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      done_r   <= 1'b0;
      first1_r <= 1'b0;
      last1_r  <= 1'b0;
      first2_r <= 1'b0;
      last2_r  <= 1'b0;
    end else begin
      v1_r     <= cmd.issue;
      first1_r <= cmd.first;
      last1_r  <= cmd.last;
      v2_r     <= v1_r;
      first2_r <= first1_r;
      last2_r  <= last1_r;
      done_r   <= v2_r && last2_r;
    end
  end

  assign sts.done  = done_r;
  assign acc_value = acc_r;

  // The final term of an element always raises done in the following cycle.
  a_done_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && last2_r) |=> done_r)
    else $error("accumulator done missing after last term");

endmodule

// File: design/mm_controller.sv
module mm_controller #(
  parameter int unsigned MAX_DIM = 8,
  parameter int unsigned DEPTH   = MAX_DIM * MAX_DIM,
  parameter int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]       cfg_data,
  // Input request handshake and decoded fields
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mm_pkg::KIND_W-1:0]      in_kind,
  input  logic [mm_pkg::POS_W-1:0]       in_row,
  input  logic [mm_pkg::POS_W-1:0]       in_col,
  // Result handshake and control fields
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic                           out_tlast,
  output logic                           out_tuser,
  output logic [mm_pkg::POS_W-1:0]       out_row,
  output logic [mm_pkg::POS_W-1:0]       out_col,
  // Datapath interface
  output mm_pkg::dp_cmd_t                cmd,
  output logic [AW-1:0]                  wr_addr,
  output logic [AW-1:0]                  rd_addr_first,
  output logic [AW-1:0]                  rd_addr_second,
  input  mm_pkg::dp_sts_t                sts
);
  import mm_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic [DIM_W-1:0] first_rows_r, first_cols_r, second_rows_r, second_cols_r;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDX_W-1:0] r1_last, c1_last, r2_last, c2_last;
  logic             load_in_range;
  logic             elem_last;

  // Clamp a dimension to 1..MAX_DIM and return its highest index.
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
    logic [5:0] d6;
    d6 = {2'b00, d};
    if (d6 == 6'd0) begin
      return '0;
    end else if (d6 > 6'(MAX_DIM)) begin
      return IDX_W'(MAX_DIM - 1);
    end else begin
      return IDX_W'(d6 - 6'd1);
    end
  endfunction

  assign r1_last = dim_last(first_rows_r);
  assign c1_last = dim_last(first_cols_r);
  assign r2_last = dim_last(second_rows_r);
  assign c2_last = dim_last(second_cols_r);

  // Store addressing is row * MAX_DIM + column.
  assign load_in_range  = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign wr_addr        = AW'(32'(in_row) * MAX_DIM + 32'(in_col));
  assign rd_addr_first  = AW'(32'(i_r) * MAX_DIM + 32'(k_r));
  assign rd_addr_second = AW'(32'(k_r) * MAX_DIM + 32'(j_r));

  assign elem_last = (i_r == r1_last) && (j_r == c2_last);
  assign out_row   = POS_W'(i_r);
  assign out_col   = POS_W'(j_r);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_rows_r  <= DIM_RESET;
      first_cols_r  <= DIM_RESET;
      second_rows_r <= DIM_RESET;
      second_cols_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIRST_ROWS:  first_rows_r  <= cfg_data;
        REG_FIRST_COLS:  first_cols_r  <= cfg_data;
        REG_SECOND_ROWS: second_rows_r <= cfg_data;
        REG_SECOND_COLS: second_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // State and loop counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // Next state and outputs.
  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    out_tlast  = 1'b0;
    out_tuser  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_kind)
            KIND_LOAD_FIRST:  cmd.wr_first  = load_in_range;
            KIND_LOAD_SECOND: cmd.wr_second = load_in_range;
            KIND_COMPUTE: begin
              i_nxt = '0;
              j_nxt = '0;
              k_nxt = '0;
              state_nxt = (c1_last != r2_last) ? ST_ERR : ST_MAC;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        // Issue one product term per cycle into the datapath.
        cmd.issue = 1'b1;
        cmd.first = (k_r == '0);
        cmd.last  = (k_r == c1_last);
        if (k_r == c1_last) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (sts.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        out_tlast  = elem_last;
        if (out_tready) begin
          if (elem_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MAC;
            if (j_r == c2_last) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
        end
      end
      ST_ERR: begin
        out_tvalid = 1'b1;
        out_tlast  = 1'b1;
        out_tuser  = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // No new request is taken while a result is pending.
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted while result pending");

  // The datapath only finishes an element while the controller waits for it.
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (state_r == ST_DRAIN))
    else $error("datapath done outside drain");

  // A last term is issued only after a first term of the same element.
  a_last_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.last && !cmd.first) |-> $past(cmd.issue))
    else $error("last term without preceding terms");

  // An error result is a single marked result at position zero.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ERR) |-> (out_tlast && out_row == '0 && out_col == '0))
    else $error("malformed dimension error result");

endmodule

// File: design/matrix_multiply.sv
// Load requests are accepted one per cycle while no compute request is running; each
// takes effect at the next cycle. A compute request with mismatched inner dimensions
// gives its error result in the next cycle. Otherwise each product element is formed
// by one store read per term, then the read, multiply and accumulate stages, then output.
// Throughput is set by the single multiply-accumulate unit and one read port per store.
// rst_n is synchronous, active low; it sets all dimensions to 8; stores are not cleared.
module matrix_multiply #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]          cfg_data,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mm_pkg::IN_DATA_W-1:0]      in_tdata,  // row_index, col_index, element_value
  input  logic [mm_pkg::KIND_W-1:0]         in_tuser,  // kind
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mm_pkg::OUT_DATA_W-1:0]     out_tdata, // out_row, out_col, out_value
  output logic                              out_tlast, // last
  output logic                              out_tuser  // dim_error
);
  import mm_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  dp_cmd_t                    cmd;
  dp_sts_t                    sts;
  logic [AW-1:0]              wr_addr, rd_addr_first, rd_addr_second;
  logic [POS_W-1:0]           in_row, in_col, out_row, out_col;
  logic signed [IN_ELEM_W-1:0] in_value;
  logic signed [VALUE_W-1:0]  acc_value, out_value;

  // Unpack the input payload.
  assign in_row   = in_tdata[POS_W-1:0];
  assign in_col   = in_tdata[2*POS_W-1:POS_W];
  assign in_value = in_tdata[2*POS_W+IN_ELEM_W-1:2*POS_W];

  // The error result carries a zero value.
  assign out_value = out_tuser ? '0 : acc_value;
  assign out_tdata = {(OUT_DATA_W - VALUE_W - 2*POS_W)'(0), out_value, out_col, out_row};

  mm_controller #(
    .MAX_DIM (MAX_DIM),
    .DEPTH   (DEPTH),
    .AW      (AW),
    .IDX_W   (IDX_W)
  ) u_ctl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_kind        (in_tuser),
    .in_row         (in_row),
    .in_col         (in_col),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .out_row        (out_row),
    .out_col        (out_col),
    .cmd            (cmd),
    .wr_addr        (wr_addr),
    .rd_addr_first  (rd_addr_first),
    .rd_addr_second (rd_addr_second),
    .sts            (sts)
  );

  mm_datapath #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .wr_addr        (wr_addr),
    .wr_data        (in_value),
    .rd_addr_first  (rd_addr_first),
    .rd_addr_second (rd_addr_second),
    .sts            (sts),
    .acc_value      (acc_value)
  );

endmodule
